// ===== hw/rtl/mlbp_pkg.sv =====
package mlbp_pkg;

  localparam int COORD_BITS = 12;
  localparam int BRUSH_BITS = 4;
  localparam int BRUSH_MAX  = 15;
  localparam int PX_BITS    = COORD_BITS + 1;
  localparam int PY_BITS    = COORD_BITS + 2;
  localparam int DEC_BITS   = 2 * COORD_BITS + 4;
  localparam int STR_BITS   = COORD_BITS + 2;
  localparam int DIAG_BITS  = COORD_BITS + 4;
  localparam int CMD_DEPTH  = 2;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } opcode_t;

  // centre pixel, then the four outline pixels of group k
  typedef enum logic [2:0] {
    PH_CENTRE  = 3'd0,
    PH_ROW     = 3'd1,
    PH_COL     = 3'd2,
    PH_FAR_COL = 3'd3,
    PH_FAR_ROW = 3'd4
  } phase_t;

  typedef struct packed {
    opcode_t                 opcode;
    logic [COORD_BITS-1:0]   start_x;
    logic [COORD_BITS-1:0]   start_y;
    logic [COORD_BITS-1:0]   end_x;
    logic [COORD_BITS-1:0]   end_y;
    logic [BRUSH_BITS-1:0]   brush_size;
  } in_item_t;

  typedef struct packed {
    logic [PX_BITS-1:0] pixel_x;
    logic [PY_BITS-1:0] pixel_y;
    logic               last_pixel;
  } out_item_t;

  typedef struct packed {
    logic                        is_start;
    logic [COORD_BITS-1:0]       start_x;
    logic [COORD_BITS-1:0]       start_y;
    logic [COORD_BITS-1:0]       stop_x;
    logic signed [DEC_BITS-1:0]  decision;
    logic signed [STR_BITS-1:0]  step_straight;
    logic signed [DIAG_BITS-1:0] step_diagonal;
    logic [BRUSH_BITS-1:0]       brush;
  } cmd_t;

  typedef struct packed {
    logic                  busy;
    logic                  pix_load;
    logic                  pix_last;
    phase_t                phase;
    logic [BRUSH_BITS-1:0] brush;
  } back_status_t;

endpackage

// ===== hw/rtl/mlbp_front.sv =====
module mlbp_front (
  input  mlbp_pkg::in_item_t item,
  output mlbp_pkg::cmd_t     cmd
);
  import mlbp_pkg::*;

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;

  always_comb begin
    dx = $signed({1'b0, item.end_x}) - $signed({1'b0, item.start_x});
    dy = $signed({1'b0, item.end_y}) - $signed({1'b0, item.start_y});
  end

  // line setup done up front so the stepper only adds
  always_comb begin
    cmd.is_start      = (item.opcode == OP_START);
    cmd.start_x       = item.start_x;
    cmd.start_y       = item.start_y;
    cmd.stop_x        = item.end_x;
    cmd.decision      = (DEC_BITS'(dy) <<< 1) - DEC_BITS'(dx);
    cmd.step_straight = STR_BITS'(dy) <<< 1;
    cmd.step_diagonal = (DIAG_BITS'(dy) - DIAG_BITS'(dx)) <<< 1;
    cmd.brush         = (int'(item.brush_size) > BRUSH_MAX) ? BRUSH_BITS'(BRUSH_MAX)
                                                            : item.brush_size;
  end

endmodule

// ===== hw/rtl/mlbp_cmd_fifo.sv =====
module mlbp_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  mlbp_pkg::cmd_t  push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output mlbp_pkg::cmd_t  pop_data
);
  import mlbp_pkg::*;

  localparam int PTR_BITS = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(CMD_DEPTH + 1);

  cmd_t                mem_r [CMD_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                push, pop;

  always_comb begin
    push_ready = (count_r != CNT_BITS'(CMD_DEPTH));
    pop_valid  = (count_r != '0);
    pop_data   = mem_r[rd_ptr_r];
    push       = push_valid && push_ready;
    pop        = pop_valid && pop_ready;

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_BITS'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_BITS'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/mlbp_back.sv =====
module mlbp_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  mlbp_pkg::cmd_t         cmd,
  output logic                   out_valid,
  input  logic                   out_ready,
  output mlbp_pkg::out_item_t    out_data,
  output mlbp_pkg::back_status_t status
);
  import mlbp_pkg::*;

  logic [COORD_BITS-1:0]       cur_x_r, cur_x_nxt;
  logic [PY_BITS-1:0]          cur_y_r, cur_y_nxt;
  logic [COORD_BITS-1:0]       stop_x_r, stop_x_nxt;
  logic signed [DEC_BITS-1:0]  decision_r, decision_nxt;
  logic signed [STR_BITS-1:0]  step_straight_r, step_straight_nxt;
  logic signed [DIAG_BITS-1:0] step_diagonal_r, step_diagonal_nxt;
  logic [BRUSH_BITS-1:0]       brush_r, brush_nxt;
  logic [BRUSH_BITS-1:0]       idx_r, idx_nxt;
  phase_t                      phase_r, phase_nxt;
  logic                        busy_r, busy_nxt;
  logic                        out_valid_r, out_valid_nxt;
  out_item_t                   out_data_r, out_data_nxt;

  logic                  out_free;
  logic                  cmd_fire;
  logic                  pix_load;
  logic                  point_done;
  logic                  line_end;
  logic [BRUSH_BITS:0]   idx_inc;
  logic [PX_BITS-1:0]    pix_x;
  logic [PY_BITS-1:0]    pix_y;

  always_comb begin
    out_free  = !out_valid_r || out_ready;
    cmd_ready = cmd.is_start || !busy_r || out_free;
    cmd_fire  = cmd_valid && cmd_ready;
    pix_load  = cmd_fire && !cmd.is_start && busy_r;
  end

  // pixel for the current phase
  always_comb begin
    unique case (phase_r)
      PH_ROW: begin
        pix_x = PX_BITS'(cur_x_r) + PX_BITS'(idx_r);
        pix_y = cur_y_r;
      end
      PH_COL: begin
        pix_x = PX_BITS'(cur_x_r);
        pix_y = cur_y_r + PY_BITS'(idx_r);
      end
      PH_FAR_COL: begin
        pix_x = PX_BITS'(cur_x_r) + PX_BITS'(brush_r);
        pix_y = cur_y_r + PY_BITS'(idx_r);
      end
      PH_FAR_ROW: begin
        pix_x = PX_BITS'(cur_x_r) + PX_BITS'(idx_r);
        pix_y = cur_y_r + PY_BITS'(brush_r);
      end
      default: begin
        pix_x = PX_BITS'(cur_x_r);
        pix_y = cur_y_r;
      end
    endcase
  end

  // brush walk and line stepping
  always_comb begin
    cur_x_nxt         = cur_x_r;
    cur_y_nxt         = cur_y_r;
    stop_x_nxt        = stop_x_r;
    decision_nxt      = decision_r;
    step_straight_nxt = step_straight_r;
    step_diagonal_nxt = step_diagonal_r;
    brush_nxt         = brush_r;
    idx_nxt           = idx_r;
    phase_nxt         = phase_r;
    busy_nxt          = busy_r;
    point_done        = 1'b0;
    line_end          = 1'b0;
    idx_inc           = {1'b0, idx_r} + (BRUSH_BITS + 1)'(1);

    if (cmd_fire && cmd.is_start) begin
      cur_x_nxt         = cmd.start_x;
      cur_y_nxt         = PY_BITS'(cmd.start_y);
      stop_x_nxt        = cmd.stop_x;
      decision_nxt      = cmd.decision;
      step_straight_nxt = cmd.step_straight;
      step_diagonal_nxt = cmd.step_diagonal;
      brush_nxt         = cmd.brush;
      idx_nxt           = '0;
      phase_nxt         = PH_CENTRE;
      busy_nxt          = 1'b1;
    end else if (pix_load) begin
      unique case (phase_r)
        PH_CENTRE: begin
          if (brush_r == '0) begin
            point_done = 1'b1;
          end else begin
            phase_nxt = PH_ROW;
            idx_nxt   = '0;
          end
        end
        PH_ROW:     phase_nxt = PH_COL;
        PH_COL:     phase_nxt = PH_FAR_COL;
        PH_FAR_COL: phase_nxt = PH_FAR_ROW;
        default: begin
          idx_nxt = idx_inc[BRUSH_BITS-1:0];
          if (idx_inc >= {1'b0, brush_r}) begin
            point_done = 1'b1;
          end else begin
            phase_nxt = PH_ROW;
          end
        end
      endcase

      if (point_done) begin
        if (cur_x_r < stop_x_r) begin
          if (decision_r[DEC_BITS-1] || decision_r == '0) begin
            decision_nxt = decision_r + DEC_BITS'(step_straight_r);
          end else begin
            decision_nxt = decision_r + DEC_BITS'(step_diagonal_r);
            cur_y_nxt    = cur_y_r + PY_BITS'(1);
          end
          cur_x_nxt = cur_x_r + COORD_BITS'(1);
          phase_nxt = PH_CENTRE;
          idx_nxt   = '0;
        end else begin
          busy_nxt = 1'b0;
          line_end = 1'b1;
        end
      end
    end
  end

  // output register
  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (pix_load) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.pixel_x    = pix_x;
      out_data_nxt.pixel_y    = pix_y;
      out_data_nxt.last_pixel = line_end;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_CENTRE;
      idx_r       <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r         <= cur_x_nxt;
    cur_y_r         <= cur_y_nxt;
    stop_x_r        <= stop_x_nxt;
    decision_r      <= decision_nxt;
    step_straight_r <= step_straight_nxt;
    step_diagonal_r <= step_diagonal_nxt;
    brush_r         <= brush_nxt;
    out_data_r      <= out_data_nxt;
  end

  always_comb begin
    out_valid       = out_valid_r;
    out_data        = out_data_r;
    status.busy     = busy_r;
    status.pix_load = pix_load;
    status.pix_last = line_end;
    status.phase    = phase_r;
    status.brush    = brush_r;
  end

endmodule

// ===== hw/rtl/midpoint_line_brush_plotter.sv =====
// Midpoint line plotter with a square-outline brush. A start word loads both endpoints and
// the brush size (saturated to the largest supported brush) and gives no output; every tick
// word after it gives one pixel: each centre point yields its centre pixel and then, for each
// k below the brush size s, (x+k,y), (x,y+k), (x+s,y+k), (x+k,y+s), with duplicates kept;
// last_pixel marks the final pixel of the line, and ticks while idle give nothing. Words pass
// through a two-entry command queue to the line stepper, which retires one word per clock while
// the output is taken, so it sustains one pixel per clock; a word goes through the queue, then
// the output register. A pixel waiting to be taken holds back only tick words of a busy line.
module midpoint_line_brush_plotter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mlbp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mlbp_pkg::out_item_t out_data
);
  import mlbp_pkg::*;

  cmd_t         front_cmd;
  cmd_t         queue_cmd;
  logic         queue_valid;
  logic         queue_ready;
  back_status_t st;

  mlbp_front u_front (
    .item (in_data),
    .cmd  (front_cmd)
  );

  mlbp_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_cmd),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_data   (queue_cmd)
  );

  mlbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (queue_valid),
    .cmd_ready (queue_ready),
    .cmd       (queue_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .status    (st)
  );

`ifndef SYNTH
  // a new pixel must never overwrite one still waiting at the output
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(st.pix_load && out_valid && !out_ready))
    else $error("pixel loaded over a pending output");

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    st.pix_load && st.pix_last |=> !st.busy)
    else $error("line still busy after its last pixel");

  a_outline_needs_brush: assert property (@(posedge clk) disable iff (!rst_n)
    st.busy && st.phase != PH_CENTRE |-> st.brush != '0)
    else $error("outline phase with zero brush");
`endif

endmodule

// ===== tb/midpoint_line_brush_plotter_tb.sv =====
module midpoint_line_brush_plotter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mlbp_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int TAIL_WAIT   = 16;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  midpoint_line_brush_plotter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // line stepper state as the block should hold it
  int unsigned line_x      = 0;
  int unsigned line_y      = 0;
  int unsigned stop_x      = 0;
  longint      decision    = 0;
  longint      step_str    = 0;
  longint      step_diag   = 0;
  int unsigned brush       = 0;
  int unsigned brush_k     = 0;
  phase_t      outline_ph  = PH_CENTRE;
  bit          line_busy   = 1'b0;

  out_item_t   expected_pixels[$];
  int          errors      = 0;
  int          words_sent  = 0;
  int          cycles      = 0;
  bit          calm        = 1'b0;
  int          stall_left  = 0;

  function automatic void trace_line_word(in_item_t w);
    out_item_t   pixel;
    int unsigned ax;
    int unsigned ay;
    longint      dx;
    longint      dy;
    bit          point_done;
    bit          last;
    if (w.opcode == OP_START) begin
      dx         = longint'(w.end_x) - longint'(w.start_x);
      dy         = longint'(w.end_y) - longint'(w.start_y);
      line_x     = w.start_x;
      line_y     = w.start_y;
      stop_x     = w.end_x;
      decision   = 2 * dy - dx;
      step_str   = 2 * dy;
      step_diag  = 2 * (dy - dx);
      brush      = (w.brush_size > BRUSH_MAX) ? BRUSH_MAX : w.brush_size;
      brush_k    = 0;
      outline_ph = PH_CENTRE;
      line_busy  = 1'b1;
    end else if (line_busy) begin
      case (outline_ph)
        PH_ROW:     begin ax = line_x + brush_k; ay = line_y;           end
        PH_COL:     begin ax = line_x;           ay = line_y + brush_k; end
        PH_FAR_COL: begin ax = line_x + brush;   ay = line_y + brush_k; end
        PH_FAR_ROW: begin ax = line_x + brush_k; ay = line_y + brush;   end
        default:    begin ax = line_x;           ay = line_y;           end
      endcase
      point_done = 1'b0;
      case (outline_ph)
        PH_CENTRE: begin
          if (brush == 0) begin
            point_done = 1'b1;
          end else begin
            outline_ph = PH_ROW;
            brush_k    = 0;
          end
        end
        PH_ROW:     outline_ph = PH_COL;
        PH_COL:     outline_ph = PH_FAR_COL;
        PH_FAR_COL: outline_ph = PH_FAR_ROW;
        default: begin
          brush_k++;
          if (brush_k >= brush) point_done = 1'b1;
          else outline_ph = PH_ROW;
        end
      endcase
      last = 1'b0;
      if (point_done) begin
        if (line_x < stop_x) begin
          if (decision <= 0) begin
            decision += step_str;
          end else begin
            decision += step_diag;
            line_y++;
          end
          line_x++;
          outline_ph = PH_CENTRE;
          brush_k    = 0;
        end else begin
          line_busy = 1'b0;
          last      = 1'b1;
        end
      end
      pixel.pixel_x    = ax[PX_BITS-1:0];
      pixel.pixel_y    = ay[PY_BITS-1:0];
      pixel.last_pixel = last;
      expected_pixels.push_back(pixel);
    end
  endfunction

  function automatic in_item_t make_start(int sx, int sy, int ex, int ey, int bs);
    in_item_t w;
    w.opcode     = OP_START;
    w.start_x    = sx[COORD_BITS-1:0];
    w.start_y    = sy[COORD_BITS-1:0];
    w.end_x      = ex[COORD_BITS-1:0];
    w.end_y      = ey[COORD_BITS-1:0];
    w.brush_size = bs[BRUSH_BITS-1:0];
    return w;
  endfunction

  // tick words carry random junk in the unused fields
  function automatic in_item_t random_tick();
    in_item_t w;
    w = make_start($urandom, $urandom, $urandom, $urandom, $urandom);
    w.opcode = OP_TICK;
    return w;
  endfunction

  task automatic send_word(in_item_t w);
    int gap;
    if (!calm && $urandom_range(0, 99) < 8) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    trace_line_word(w);
    words_sent++;
  endtask

  task automatic draw_line(in_item_t start_word, int tick_cap, int spare_ticks);
    int n;
    n = 0;
    send_word(start_word);
    while (line_busy && n < tick_cap) begin
      send_word(random_tick());
      n++;
    end
    repeat (spare_ticks) send_word(random_tick());
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic test_idle_ticks();
    repeat (2) send_word(random_tick());
  endtask

  task automatic test_extremes();
    // single point at the origin, then a tick once the line has ended
    draw_line(make_start(0, 0, 0, 0, 0), 1, 1);
    // largest brush at the far corner, cut short by the next start
    draw_line(make_start(4095, 4095, 4095, 4095, 15), 6, 0);
  endtask

  task automatic test_restart();
    draw_line(make_start(10, 20, 13, 21, 0), 4, 0);
  endtask

  task automatic test_slopes();
    draw_line(make_start(100, 4095, 102, 0, 0), 3, 0);
    draw_line(make_start(0, 0, 1, 4095, 0), 2, 0);
    // end left of start: only the start point and its brush outline are drawn
    draw_line(make_start(50, 5, 40, 9, 1), 5, 0);
  endtask

  task automatic random_lines(int target);
    int sx, sy, ex, ey, bs, pick, cap;
    while (words_sent < target) begin
      sx   = $urandom_range(0, 4095);
      sy   = $urandom_range(0, 4095);
      pick = $urandom_range(0, 99);
      if (pick < 70) ex = (sx + $urandom_range(0, 5) > 4095) ? 4095 : sx + $urandom_range(0, 5);
      else if (pick < 85) ex = $urandom_range(0, sx);
      else ex = $urandom_range(0, 4095);
      if ($urandom_range(0, 99) < 60)
        ey = (sy + $urandom_range(0, 6) > 4095) ? 4095 : sy + $urandom_range(0, 6);
      else
        ey = $urandom_range(0, 4095);
      bs  = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 3) : $urandom_range(0, 15);
      cap = ($urandom_range(0, 99) < 85) ? 400 : $urandom_range(0, 20);
      draw_line(make_start(sx, sy, ex, ey, bs), cap, $urandom_range(0, 2));
    end
  endtask

  task automatic test_drain_pause();
    draw_line(make_start(200, 300, 203, 302, 2), 10, 0);
    wait_for_drain();
    draw_line(make_start(200, 300, 203, 302, 2), 400, 1);
  endtask

  task automatic test_quiet_tail(int target);
    calm = 1'b1;
    random_lines(target);
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_ready <= 1'b1;
    end else if (!calm && $urandom_range(0, 99) < 8) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(1, 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d last=%0b",
               out_data.pixel_x, out_data.pixel_y, out_data.last_pixel);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.pixel_x !== want.pixel_x) begin
          $error("pixel_x: expected %0d, got %0d", want.pixel_x, out_data.pixel_x);
          errors++;
        end
        if (out_data.pixel_y !== want.pixel_y) begin
          $error("pixel_y: expected %0d, got %0d", want.pixel_y, out_data.pixel_y);
          errors++;
        end
        if (out_data.last_pixel !== want.last_pixel) begin
          $error("last_pixel: expected %0b, got %0b", want.last_pixel, out_data.last_pixel);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_ticks();
    test_extremes();
    test_restart();
    test_slopes();
    random_lines(700);
    test_drain_pause();
    random_lines(1300);
    test_quiet_tail(1450);
    wait_for_drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
